// ----- src/txtok_pkg.sv -----
// Shared types, token kind codes and the opcode index table for the tokenizer.
// No dependencies; used by txtok_parser and txout_list_script_tokenizer.
package txtok_pkg;

    localparam logic [2:0] KIND_COUNT  = 3'd0;
    localparam logic [2:0] KIND_VALUE  = 3'd1;
    localparam logic [2:0] KIND_LENGTH = 3'd2;
    localparam logic [2:0] KIND_OPCODE = 3'd3;
    localparam logic [2:0] KIND_PUSH   = 3'd4;
    localparam logic [2:0] KIND_DATA   = 3'd5;

    localparam int OPC_COUNT = 110;
    localparam logic [7:0] PUSH_MAX = 8'h4b;
    localparam logic [7:0] VARINT_2 = 8'hfd;
    localparam logic [7:0] VARINT_4 = 8'hfe;

    localparam logic [7:0] OPC_TABLE [OPC_COUNT] = '{
        8'h00,8'h01,8'h4b,8'h4c,8'h4d,8'h4e,8'h4f,8'h51,8'h52,8'h53,8'h54,8'h55,8'h56,8'h57,
        8'h58,8'h59,8'h5a,8'h5b,8'h5c,8'h5d,8'h5e,8'h5f,8'h60,8'h61,8'h63,8'h64,8'h67,8'h68,
        8'h69,8'h6a,8'h6b,8'h6c,8'h73,8'h74,8'h75,8'h76,8'h77,8'h78,8'h79,8'h7a,8'h7b,8'h7c,
        8'h7d,8'h6d,8'h6e,8'h6f,8'h70,8'h71,8'h72,8'h7e,8'h7f,8'h80,8'h81,8'h82,8'h83,8'h84,
        8'h85,8'h86,8'h87,8'h88,8'h8b,8'h8c,8'h8d,8'h8e,8'h8f,8'h90,8'h91,8'h92,8'h93,8'h94,
        8'h95,8'h96,8'h97,8'h98,8'h99,8'h9a,8'h9b,8'h9c,8'h9d,8'h9e,8'h9f,8'ha0,8'ha1,8'ha2,
        8'ha3,8'ha4,8'ha5,8'ha6,8'ha7,8'ha8,8'ha9,8'haa,8'hab,8'hac,8'had,8'hae,8'haf,8'hb1,
        8'hb2,8'hfd,8'hfe,8'hff,8'h50,8'h62,8'h65,8'h66,8'h89,8'h8a,8'hb0,8'hb9
    };

    typedef struct packed {
        logic [2:0]  kind;
        logic [63:0] value;
        logic [6:0]  opc_index;
        logic        end_of_output;
        logic        end_of_list;
    } token_t;

    function automatic logic [6:0] opcode_index_of(input logic [7:0] b);
        logic [6:0] idx;
        idx = 7'(OPC_COUNT);
        for (int i = OPC_COUNT - 1; i >= 0; i--) begin
            if (OPC_TABLE[i] == b)
            begin
                idx = 7'(i);
            end
        end
        return idx;
    endfunction

endpackage

// ----- src/txout_list_script_tokenizer.sv -----
// A token appears in the result register in the cycle after its byte is accepted.
// Throughput: one byte per cycle; the byte is decoded in a single pass against the
// parse state, and the input stalls only while a held result is stalled at the output.
// Bytes inside a multi-byte field give no token until the field completes.
// Reset (rst_n low, asynchronous) empties the result register and returns the parser
// to expecting an output count with all counters cleared.
module txout_list_script_tokenizer (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [7:0]  in_byte,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [2:0]  token_kind,
    output logic [63:0] token_value,
    output logic [6:0]  opcode_index,
    output logic        end_of_output,
    output logic        end_of_list
);

    logic               take;
    logic               tok_valid;
    txtok_pkg::token_t  tok;
    logic               out_valid_reg;
    txtok_pkg::token_t  out_tok_reg;

    assign in_stall = out_valid_reg & out_stall;
    assign take     = in_valid & ~in_stall;

    txtok_parser u_parser (
        .clk       (clk),
        .rst_n     (rst_n),
        .take      (take),
        .in_byte   (in_byte),
        .tok_valid (tok_valid),
        .tok       (tok)
    );

    // hold result until taken; load a new transaction when one is produced
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (take)
        begin
            out_valid_reg <= tok_valid;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && tok_valid)
        begin
            out_tok_reg <= tok;
        end
    end

    assign out_valid     = out_valid_reg;
    assign token_kind    = out_tok_reg.kind;
    assign token_value   = out_tok_reg.value;
    assign opcode_index  = out_tok_reg.opc_index;
    assign end_of_output = out_tok_reg.end_of_output;
    assign end_of_list   = out_tok_reg.end_of_list;

endmodule

// ----- src/txtok_parser.sv -----
// Parse state and per-byte token decode for the output list byte stream.
// Depends on txtok_pkg for the token struct, kind codes and opcode table.
module txtok_parser (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               take,
    input  logic [7:0]         in_byte,
    output logic               tok_valid,
    output txtok_pkg::token_t  tok
);

    localparam logic [2:0] PH_CNT0   = 3'd0;
    localparam logic [2:0] PH_CNTX   = 3'd1;
    localparam logic [2:0] PH_VALUE  = 3'd2;
    localparam logic [2:0] PH_LEN0   = 3'd3;
    localparam logic [2:0] PH_LENX   = 3'd4;
    localparam logic [2:0] PH_SCRIPT = 3'd5;
    localparam logic [2:0] PH_PUSH   = 3'd6;

    logic [2:0]  phase_reg, phase_next;
    logic [3:0]  fbl_reg, fbl_next;
    logic [63:0] acc_reg, acc_next;
    logic [3:0]  pos_reg, pos_next;
    logic [63:0] outs_reg, outs_next;
    logic [63:0] sbl_reg, sbl_next;
    logic [6:0]  pbl_reg, pbl_next;

    logic [63:0] acc_add;
    logic [3:0]  fbl_dec;
    logic        field_done;
    logic [63:0] outs_dec;
    logic        last_out;
    logic [63:0] sbl_dec;
    logic        script_end;
    logic [6:0]  pbl_dec;
    logic [3:0]  tail_len;
    logic        is_push;

    always_comb
    begin
        acc_add    = acc_reg | ({56'd0, in_byte} << {pos_reg[2:0], 3'b000});
        fbl_dec    = (fbl_reg != 4'd0) ? fbl_reg - 4'd1 : 4'd0;
        field_done = (fbl_dec == 4'd0);
        outs_dec   = (outs_reg != 64'd0) ? outs_reg - 64'd1 : 64'd0;
        last_out   = (outs_dec == 64'd0);
        sbl_dec    = (sbl_reg != 64'd0) ? sbl_reg - 64'd1 : 64'd0;
        script_end = (sbl_dec == 64'd0);
        pbl_dec    = (pbl_reg != 7'd0) ? pbl_reg - 7'd1 : 7'd0;
        tail_len   = (in_byte == txtok_pkg::VARINT_2) ? 4'd2 :
                     ((in_byte == txtok_pkg::VARINT_4) ? 4'd4 : 4'd8);
        is_push    = (in_byte >= 8'd1) && (in_byte <= txtok_pkg::PUSH_MAX);
    end

    always_comb
    begin
        phase_next = phase_reg;
        fbl_next   = fbl_reg;
        acc_next   = acc_reg;
        pos_next   = pos_reg;
        outs_next  = outs_reg;
        sbl_next   = sbl_reg;
        pbl_next   = pbl_reg;
        tok_valid  = 1'b0;
        tok.kind          = txtok_pkg::KIND_COUNT;
        tok.value         = {56'd0, in_byte};
        tok.opc_index     = 7'd0;
        tok.end_of_output = 1'b0;
        tok.end_of_list   = 1'b0;

        case (phase_reg)
            PH_CNTX, PH_VALUE, PH_LENX:
            begin
                acc_next = acc_add;
                pos_next = pos_reg + 4'd1;
                fbl_next = fbl_dec;
                tok.value = acc_add;
                if (field_done)
                begin
                    tok_valid = 1'b1;
                    if (phase_reg == PH_CNTX)
                    begin
                        tok.kind = txtok_pkg::KIND_COUNT;
                        outs_next = acc_add;
                        if (acc_add == 64'd0)
                        begin
                            tok.end_of_list = 1'b1;
                            phase_next = PH_CNT0;
                        end
                        else
                        begin
                            phase_next = PH_VALUE;
                            fbl_next = 4'd8;
                            acc_next = 64'd0;
                            pos_next = 4'd0;
                        end
                    end
                    else if (phase_reg == PH_VALUE)
                    begin
                        tok.kind = txtok_pkg::KIND_VALUE;
                        phase_next = PH_LEN0;
                    end
                    else
                    begin
                        tok.kind = txtok_pkg::KIND_LENGTH;
                        sbl_next = acc_add;
                        if (acc_add == 64'd0)
                        begin
                            tok.end_of_output = 1'b1;
                            tok.end_of_list = last_out;
                            outs_next = outs_dec;
                            phase_next = last_out ? PH_CNT0 : PH_VALUE;
                            fbl_next = 4'd8;
                            acc_next = 64'd0;
                            pos_next = 4'd0;
                        end
                        else
                        begin
                            phase_next = PH_SCRIPT;
                        end
                    end
                end
            end
            PH_LEN0:
            begin
                if (in_byte < txtok_pkg::VARINT_2)
                begin
                    tok_valid = 1'b1;
                    tok.kind = txtok_pkg::KIND_LENGTH;
                    sbl_next = {56'd0, in_byte};
                    if (in_byte == 8'd0)
                    begin
                        tok.end_of_output = 1'b1;
                        tok.end_of_list = last_out;
                        outs_next = outs_dec;
                        phase_next = last_out ? PH_CNT0 : PH_VALUE;
                        fbl_next = 4'd8;
                        acc_next = 64'd0;
                        pos_next = 4'd0;
                    end
                    else
                    begin
                        phase_next = PH_SCRIPT;
                    end
                end
                else
                begin
                    fbl_next = tail_len;
                    acc_next = 64'd0;
                    pos_next = 4'd0;
                    phase_next = PH_LENX;
                end
            end
            PH_SCRIPT, PH_PUSH:
            begin
                tok_valid = 1'b1;
                sbl_next = sbl_dec;
                tok.end_of_output = script_end;
                tok.end_of_list = script_end & last_out;
                if (phase_reg == PH_PUSH)
                begin
                    tok.kind = txtok_pkg::KIND_DATA;
                    pbl_next = pbl_dec;
                    if (!script_end && pbl_dec == 7'd0)
                    begin
                        phase_next = PH_SCRIPT;
                    end
                end
                else if (is_push)
                begin
                    tok.kind = txtok_pkg::KIND_PUSH;
                    pbl_next = ({56'd0, in_byte} <= sbl_dec) ? in_byte[6:0] : sbl_dec[6:0];
                    phase_next = PH_PUSH;
                end
                else
                begin
                    tok.kind = txtok_pkg::KIND_OPCODE;
                    tok.opc_index = txtok_pkg::opcode_index_of(in_byte);
                end
                if (script_end)
                begin
                    outs_next = outs_dec;
                    phase_next = last_out ? PH_CNT0 : PH_VALUE;
                    fbl_next = 4'd8;
                    acc_next = 64'd0;
                    pos_next = 4'd0;
                end
            end
            default:
            begin
                if (in_byte < txtok_pkg::VARINT_2)
                begin
                    tok_valid = 1'b1;
                    tok.kind = txtok_pkg::KIND_COUNT;
                    outs_next = {56'd0, in_byte};
                    if (in_byte == 8'd0)
                    begin
                        tok.end_of_list = 1'b1;
                        phase_next = PH_CNT0;
                    end
                    else
                    begin
                        phase_next = PH_VALUE;
                        fbl_next = 4'd8;
                        acc_next = 64'd0;
                        pos_next = 4'd0;
                    end
                end
                else
                begin
                    fbl_next = tail_len;
                    acc_next = 64'd0;
                    pos_next = 4'd0;
                    phase_next = PH_CNTX;
                end
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_CNT0;
            fbl_reg   <= 4'd0;
            acc_reg   <= 64'd0;
            pos_reg   <= 4'd0;
            outs_reg  <= 64'd0;
            sbl_reg   <= 64'd0;
            pbl_reg   <= 7'd0;
        end
        else if (take)
        begin
            phase_reg <= phase_next;
            fbl_reg   <= fbl_next;
            acc_reg   <= acc_next;
            pos_reg   <= pos_next;
            outs_reg  <= outs_next;
            sbl_reg   <= sbl_next;
            pbl_reg   <= pbl_next;
        end
    end

endmodule
